### hw/rtl/trisr_pkg.sv
// Shared widths and types for the triangle scanline rasteriser.
`timescale 1ns / 1ps
package trisr_pkg;

  localparam int XW         = 16;  // vertex and span coordinate width
  localparam int DYW        = 17;  // height of one part, always positive
  localparam int COLOR_W    = 24;
  localparam int SLOPE_BITS = 16;  // extra fraction bits on edge values
  localparam int SW         = 40;  // slopes, corners and numerators
  localparam int ACC_W      = 48;  // edge accumulators
  localparam int YW         = 18;  // row walker y
  localparam int CNT_W      = 6;   // iteration counter of the shared unit

  typedef logic signed [SW-1:0]    wide_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // Place a Q12.4 x into the wide edge format.
  function automatic wide_t widen_x(input logic signed [XW-1:0] x);
    widen_x = {{(SW-XW-SLOPE_BITS){x[XW-1]}}, x, {SLOPE_BITS{1'b0}}};
  endfunction

endpackage

### hw/rtl/triangle_scanline_rasterizer_core.sv
// Triangle scanline rasteriser: vertex sort, iterative slope setup and row walk.
`timescale 1ns / 1ps
// Usage:
//   Present a triangle on the vertex, colour and flag ports and raise start;
//   the triangle is taken at a clock edge where start is high and busy low.
//   Spans leave on span_* ports, each valid for one cycle under span_valid;
//   the receiver cannot stall, so each span must be taken when shown.
//   last_span marks the final span of a triangle; busy falls in the cycle
//   that span is shown. A dropped triangle gives no span and leaves busy low;
//   one with no row in the band is still walked in full but gives no span.
//   Write band_top_row with band_top_row_we while busy is low; it is unchecked.
// Operation:
//   A restoring divider gives one quotient bit per cycle for each slope.
//   A general triangle first divides for the long-edge slope and then runs
//   a shift-add multiply for the split point; a flat one skips both. Each
//   part then takes one setup step, two slope divisions, one walk step per
//   row of the part (all rows, not only those inside the band) and one exit
//   step; a final flush step ends the item. Each span is held until the
//   next in-band row is walked; the last one leaves from the flush step.
// Reset:
//   rst clears the sequencer, the pending span and band_top_row to zero.
module triangle_scanline_rasterizer_core
  import trisr_pkg::*;
#(
  parameter int BAND_ROWS = 32,
  parameter int FRAC_BITS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [XW-1:0]      vertex0_x,
  input  logic signed [XW-1:0]      vertex0_y,
  input  logic signed [XW-1:0]      vertex1_x,
  input  logic signed [XW-1:0]      vertex1_y,
  input  logic signed [XW-1:0]      vertex2_x,
  input  logic signed [XW-1:0]      vertex2_y,
  input  logic [COLOR_W-1:0]        tri_color,
  input  logic                      is_active,
  input  logic                      is_clipped,
  input  logic                      is_backface,
  input  logic                      band_top_row_we,
  input  logic [11:0]               band_top_row,
  output logic                      span_valid,
  output logic signed [XW-1:0]      span_y,
  output logic signed [XW-1:0]      span_left_x,
  output logic signed [XW-1:0]      span_right_x,
  output logic [COLOR_W-1:0]        span_color,
  output logic                      last_span
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV01, S_MUL, S_PREP, S_DIVL, S_DIVR, S_WALK, S_FLUSH
  } state_t;

  localparam logic signed [YW-1:0] ONE = YW'(1) << FRAC_BITS;

  state_t state;
  logic [11:0] band_row;

  // sorted vertices and setup values
  logic signed [XW-1:0] sx0, sx1, sx2, sy0, sy1, sy2;
  logic [COLOR_W-1:0]   color;
  wide_t                apex, ca, cb, l_c, r_c, slope_l;
  logic signed [XW-1:0] ytop, ylow;
  logic                 ptop, more;

  // shared divide / multiply unit
  logic [SW-1:0]  dv_num;
  logic [DYW:0]   dv_rem;
  logic [DYW-1:0] dv_den;
  logic           dv_neg;
  logic [CNT_W-1:0] cnt;
  wide_t          mul_a, mul_p;
  logic [DYW-1:0] mul_b;

  // walker
  acc_t               acc_l, acc_r, step_l, step_r;
  logic signed [YW-1:0] y;

  // pending span, held until the next one shows whether it is the last
  logic                 pend_valid;
  logic signed [XW-1:0] pend_y, pend_lx, pend_rx;

  // sort by y so that y0 <= y2 <= y1
  logic signed [XW-1:0] a_x0, a_y0, a_x1, a_y1, b_x1, b_y1, b_x2, b_y2;
  logic signed [XW-1:0] c_x0, c_y0, c_x2, c_y2;
  logic drop;

  always_comb begin
    a_x0 = vertex0_x; a_y0 = vertex0_y; a_x1 = vertex1_x; a_y1 = vertex1_y;
    if (vertex0_y > vertex1_y) begin
      a_x0 = vertex1_x; a_y0 = vertex1_y; a_x1 = vertex0_x; a_y1 = vertex0_y;
    end
    b_x1 = a_x1; b_y1 = a_y1; b_x2 = vertex2_x; b_y2 = vertex2_y;
    if (vertex2_y > a_y1) begin
      b_x1 = vertex2_x; b_y1 = vertex2_y; b_x2 = a_x1; b_y2 = a_y1;
    end
    c_x0 = a_x0; c_y0 = a_y0; c_x2 = b_x2; c_y2 = b_y2;
    if (a_y0 > b_y2) begin
      c_x0 = b_x2; c_y0 = b_y2; c_x2 = a_x0; c_y2 = a_y0;
    end
    drop = !is_active || is_clipped || is_backface ||
           (vertex0_x == vertex2_x && vertex2_x == vertex1_x) ||
           (vertex1_y == vertex2_y && vertex2_y == vertex0_y);
  end

  // divider step: one quotient bit per cycle
  logic [DYW:0]  rem_sh;
  logic          q_bit;
  wide_t         quot;
  always_comb begin
    rem_sh = {dv_rem[DYW-1:0], dv_num[SW-1]};
    q_bit  = rem_sh >= {1'b0, dv_den};
    quot   = dv_neg ? -$signed({dv_num[SW-2:0], q_bit})
                    : $signed({dv_num[SW-2:0], q_bit});
  end

  // part setup values: ordered corners and numerators
  wide_t lo_c, hi_c, num_l, num_r;
  logic [DYW-1:0] height;
  always_comb begin
    lo_c   = (ca < cb) ? ca : cb;
    hi_c   = (ca < cb) ? cb : ca;
    num_l  = ptop ? (apex - lo_c) : (lo_c - apex);
    num_r  = ptop ? (apex - r_c) : (r_c - apex);
    height = DYW'({ylow[XW-1], ylow} - {ytop[XW-1], ytop});
  end

  // row band test and span ends
  logic signed [YW-1:0] row;
  logic signed [YW:0]   rel;
  logic                 in_band;
  logic signed [ACC_W-SLOPE_BITS-1:0] xl_w, xr_w;
  logic signed [XW-1:0] xl, xr;
  localparam logic signed [ACC_W-SLOPE_BITS-1:0] XMAX = 32767;
  localparam logic signed [ACC_W-SLOPE_BITS-1:0] XMIN = -32768;
  always_comb begin
    row     = y >>> FRAC_BITS;
    rel     = {row[YW-1], row} - $signed({{(YW-11){1'b0}}, band_row});
    in_band = !row[YW-1] && !rel[YW] && (rel < (YW+1)'(BAND_ROWS));
    xl_w    = acc_l[ACC_W-1:SLOPE_BITS];
    xr_w    = acc_r[ACC_W-1:SLOPE_BITS];
    xl = (xl_w > XMAX) ? XW'(XMAX) : (xl_w < XMIN) ? XW'(XMIN) : xl_w[XW-1:0];
    xr = (xr_w > XMAX) ? XW'(XMAX) : (xr_w < XMIN) ? XW'(XMIN) : xr_w[XW-1:0];
  end

  assign busy = (state != S_IDLE);

  // band register
  always_ff @(posedge clk) begin
    if (rst) begin
      band_row <= '0;
    end else if (band_top_row_we) begin
      band_row <= band_top_row;
    end
  end

  // sequencer, shared unit and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      span_valid <= 1'b0;
      last_span  <= 1'b0;
    end else begin
      span_valid <= 1'b0;
      last_span  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && !drop) begin
            sx0 <= c_x0; sy0 <= c_y0; sx1 <= b_x1; sy1 <= b_y1;
            sx2 <= c_x2; sy2 <= c_y2;
            color      <= tri_color;
            pend_valid <= 1'b0;
            if (c_y0 == c_y2) begin
              // flat top only
              ptop <= 1'b1; more <= 1'b0;
              apex <= widen_x(b_x1); ca <= widen_x(c_x0); cb <= widen_x(c_x2);
              ytop <= c_y0; ylow <= b_y1;
              state <= S_PREP;
            end else if (c_y2 == b_y1) begin
              // flat bottom only
              ptop <= 1'b0; more <= 1'b0;
              apex <= widen_x(c_x0); ca <= widen_x(c_x2); cb <= widen_x(b_x1);
              ytop <= c_y0; ylow <= b_y1;
              state <= S_PREP;
            end else begin
              // slope of the long edge
              dv_neg <= widen_x(b_x1) < widen_x(c_x0);
              dv_num <= (widen_x(b_x1) < widen_x(c_x0))
                        ? widen_x(c_x0) - widen_x(b_x1)
                        : widen_x(b_x1) - widen_x(c_x0);
              dv_den <= DYW'({b_y1[XW-1], b_y1} - {c_y0[XW-1], c_y0});
              dv_rem <= '0;
              cnt    <= '0;
              state  <= S_DIV01;
            end
          end
        end
        S_DIV01: begin
          dv_rem <= q_bit ? rem_sh - {1'b0, dv_den} : rem_sh;
          dv_num <= {dv_num[SW-2:0], q_bit};
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(SW-1)) begin
            mul_a <= quot;
            mul_b <= DYW'({sy1[XW-1], sy1} - {sy2[XW-1], sy2});
            mul_p <= '0;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // shift-add multiply for the split point
          if (mul_b[0]) mul_p <= mul_p + mul_a;
          mul_a <= mul_a <<< 1;
          mul_b <= mul_b >> 1;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(DYW-1)) begin
            ptop <= 1'b0; more <= 1'b1;
            apex <= widen_x(sx0);
            ca   <= widen_x(sx1) - (mul_b[0] ? mul_p + mul_a : mul_p);
            cb   <= widen_x(sx2);
            ytop <= sy0; ylow <= sy2;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          l_c    <= lo_c;
          r_c    <= hi_c;
          dv_neg <= num_l[SW-1];
          dv_num <= num_l[SW-1] ? -num_l : num_l;
          dv_den <= height;
          dv_rem <= '0;
          cnt    <= '0;
          state  <= S_DIVL;
        end
        S_DIVL: begin
          dv_rem <= q_bit ? rem_sh - {1'b0, dv_den} : rem_sh;
          dv_num <= {dv_num[SW-2:0], q_bit};
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(SW-1)) begin
            slope_l <= quot;
            dv_neg  <= num_r[SW-1];
            dv_num  <= num_r[SW-1] ? -num_r : num_r;
            dv_rem  <= '0;
            cnt     <= '0;
            state   <= S_DIVR;
          end
        end
        S_DIVR: begin
          dv_rem <= q_bit ? rem_sh - {1'b0, dv_den} : rem_sh;
          dv_num <= {dv_num[SW-2:0], q_bit};
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(SW-1)) begin
            step_l <= ACC_W'(slope_l) <<< FRAC_BITS;
            step_r <= ACC_W'(quot) <<< FRAC_BITS;
            acc_l  <= ptop ? ACC_W'(l_c) : ACC_W'(apex);
            acc_r  <= ptop ? ACC_W'(r_c) : ACC_W'(apex);
            y      <= YW'(ytop);
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (y < YW'(ylow)) begin
            if (in_band) begin
              // send the held span, keep this one
              if (pend_valid) begin
                span_valid   <= 1'b1;
                span_y       <= pend_y;
                span_left_x  <= pend_lx;
                span_right_x <= pend_rx;
                span_color   <= color;
              end
              pend_valid <= 1'b1;
              pend_y     <= y[XW-1:0];
              pend_lx    <= xl;
              pend_rx    <= xr;
            end
            acc_l <= acc_l + step_l;
            acc_r <= acc_r + step_r;
            y     <= y + ONE;
          end else if (more) begin
            // flat-top half below the split
            ptop <= 1'b1; more <= 1'b0;
            apex <= widen_x(sx1);
            ytop <= sy2; ylow <= sy1;
            state <= S_PREP;
          end else begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (pend_valid) begin
            span_valid   <= 1'b1;
            last_span    <= 1'b1;
            span_y       <= pend_y;
            span_left_x  <= pend_lx;
            span_right_x <= pend_rx;
            span_color   <= color;
          end
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
